// ===== rtl/positional_list_insert_remove_defines.svh =====
// assertion helpers used by the list sequencer rtl
`ifndef POSITIONAL_LIST_INSERT_REMOVE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_REMOVE_DEFINES_SVH

// same-cycle implication, checked on every edge out of reset
`define PLI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every edge out of reset
`define PLI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pli_pkg.sv =====
package pli_pkg;

    // fixed field widths
    localparam int ACT_W = 3;
    localparam int POS_W = 6;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int NC_W  = 7;

    // action codes
    localparam logic [ACT_W-1:0] ACT_APPEND   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FRONT    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INS_AT   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REM_AT   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REM_LAST = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ     = 3'd5;

    // status codes
    localparam logic [ST_W-1:0] STS_DONE = 2'd0;
    localparam logic [ST_W-1:0] STS_BAD  = 2'd1;
    localparam logic [ST_W-1:0] STS_FULL = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_GRAB,
        ST_SHIFT,
        ST_FINAL
    } t_state;

    // kind of work a request turns into
    typedef enum logic [1:0] {
        K_NONE,
        K_INS,
        K_REM,
        K_READ
    } t_kind;

    // one finished result
    typedef struct packed {
        logic              ok;
        logic [ST_W-1:0]   status;
        logic [VAL_W-1:0]  out_value;
        logic [NC_W-1:0]   new_count;
    } t_result;

endpackage

// ===== rtl/pli_ram.sv =====
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pli_seq.sv =====
`include "positional_list_insert_remove_defines.svh"

module pli_seq #(
    parameter int CAPACITY = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  logic [pli_pkg::ACT_W-1:0]     i_action,
    input  logic [pli_pkg::POS_W-1:0]     i_position,
    input  logic [pli_pkg::VAL_W-1:0]     i_item_value,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output pli_pkg::t_result              o_res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > pli_pkg::POS_W) ? CW : pli_pkg::POS_W;

    pli_pkg::t_state r_state, n_state;
    pli_pkg::t_kind  r_kind, n_kind;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_new_count, n_new_count;
    logic [CW-1:0]   r_left, n_left;
    logic [AW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_ptr, n_ptr;
    logic [AW-1:0]   r_wb_addr, n_wb_addr;
    logic            r_wb_valid, n_wb_valid;
    logic [pli_pkg::VAL_W-1:0] r_value, n_value;
    logic [pli_pkg::VAL_W-1:0] r_result, n_result;
    logic            r_ok, n_ok;
    logic [pli_pkg::ST_W-1:0]  r_status, n_status;

    // request decode
    pli_pkg::t_kind            d_kind;
    logic                      d_ok;
    logic [pli_pkg::ST_W-1:0]  d_status;
    logic [AW-1:0]             d_idx;
    logic                      full;
    logic                      in_range;
    logic                      accept;

    // memory port controls
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [pli_pkg::VAL_W-1:0] ram_wdata;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [pli_pkg::VAL_W-1:0] ram_rdata;

    assign full     = (r_count == CW'(CAPACITY));
    assign in_range = (XW'(i_position) < XW'(r_count));
    assign accept   = i_req_valid && o_req_ready;

    // classify the incoming request against the current count
    always_comb begin
        d_kind   = pli_pkg::K_NONE;
        d_ok     = 1'b0;
        d_status = pli_pkg::STS_BAD;
        d_idx    = '0;
        case (i_action)
            pli_pkg::ACT_APPEND, pli_pkg::ACT_FRONT: begin
                if (full) begin
                    d_status = pli_pkg::STS_FULL;
                end else begin
                    d_kind   = pli_pkg::K_INS;
                    d_ok     = 1'b1;
                    d_status = pli_pkg::STS_DONE;
                    d_idx    = (i_action == pli_pkg::ACT_APPEND) ? AW'(r_count) : '0;
                end
            end
            pli_pkg::ACT_INS_AT: begin
                if (!in_range) begin
                    d_status = pli_pkg::STS_BAD;
                end else if (full) begin
                    d_status = pli_pkg::STS_FULL;
                end else begin
                    d_kind   = pli_pkg::K_INS;
                    d_ok     = 1'b1;
                    d_status = pli_pkg::STS_DONE;
                    d_idx    = AW'(i_position);
                end
            end
            pli_pkg::ACT_REM_AT: begin
                if (in_range) begin
                    d_kind   = pli_pkg::K_REM;
                    d_ok     = 1'b1;
                    d_status = pli_pkg::STS_DONE;
                    d_idx    = AW'(i_position);
                end
            end
            pli_pkg::ACT_REM_LAST: begin
                if (r_count != '0) begin
                    d_kind   = pli_pkg::K_REM;
                    d_ok     = 1'b1;
                    d_status = pli_pkg::STS_DONE;
                    d_idx    = AW'(r_count - 1'b1);
                end
            end
            pli_pkg::ACT_READ: begin
                if (in_range) begin
                    d_kind   = pli_pkg::K_READ;
                    d_ok     = 1'b1;
                    d_status = pli_pkg::STS_DONE;
                    d_idx    = AW'(i_position);
                end
            end
            default: begin
                d_kind = pli_pkg::K_NONE;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pli_pkg::ST_IDLE: begin
                if (accept) begin
                    case (d_kind)
                        pli_pkg::K_INS:            n_state = pli_pkg::ST_SHIFT;
                        pli_pkg::K_REM, pli_pkg::K_READ: n_state = pli_pkg::ST_FETCH;
                        default:                   n_state = pli_pkg::ST_FINAL;
                    endcase
                end
            end
            pli_pkg::ST_FETCH: n_state = pli_pkg::ST_GRAB;
            pli_pkg::ST_GRAB: begin
                n_state = (r_kind == pli_pkg::K_REM) ? pli_pkg::ST_SHIFT : pli_pkg::ST_FINAL;
            end
            pli_pkg::ST_SHIFT: begin
                if (r_left == '0 && !r_wb_valid) begin
                    n_state = pli_pkg::ST_FINAL;
                end
            end
            pli_pkg::ST_FINAL: begin
                if (i_res_ready) begin
                    n_state = pli_pkg::ST_IDLE;
                end
            end
            default: n_state = pli_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_kind      = r_kind;
        n_count     = r_count;
        n_new_count = r_new_count;
        n_left      = r_left;
        n_idx       = r_idx;
        n_ptr       = r_ptr;
        n_wb_addr   = r_wb_addr;
        n_wb_valid  = 1'b0;
        n_value     = r_value;
        n_result    = r_result;
        n_ok        = r_ok;
        n_status    = r_status;
        ram_we      = 1'b0;
        ram_waddr   = r_wb_addr;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = r_ptr;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            pli_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (accept) begin
                    n_kind   = d_kind;
                    n_ok     = d_ok;
                    n_status = d_status;
                    n_idx    = d_idx;
                    n_value  = i_item_value;
                    case (d_kind)
                        pli_pkg::K_INS: begin
                            n_ptr       = AW'(r_count - 1'b1);
                            n_left      = r_count - CW'(d_idx);
                            n_new_count = r_count + 1'b1;
                        end
                        pli_pkg::K_REM: begin
                            n_ptr       = d_idx + 1'b1;
                            n_left      = r_count - CW'(d_idx) - 1'b1;
                            n_new_count = r_count - 1'b1;
                        end
                        default: begin
                            n_left      = '0;
                            n_new_count = r_count;
                        end
                    endcase
                end
            end
            pli_pkg::ST_FETCH: begin
                ram_re    = 1'b1;
                ram_raddr = r_idx;
            end
            pli_pkg::ST_GRAB: begin
                n_result = ram_rdata;
            end
            pli_pkg::ST_SHIFT: begin
                // write back the entry read last cycle one place over
                ram_we    = r_wb_valid;
                ram_waddr = r_wb_addr;
                ram_wdata = ram_rdata;
                if (r_left != '0) begin
                    ram_re     = 1'b1;
                    ram_raddr  = r_ptr;
                    n_left     = r_left - 1'b1;
                    n_wb_valid = 1'b1;
                    if (r_kind == pli_pkg::K_INS) begin
                        n_ptr     = r_ptr - 1'b1;
                        n_wb_addr = r_ptr + 1'b1;
                    end else begin
                        n_ptr     = r_ptr + 1'b1;
                        n_wb_addr = r_ptr - 1'b1;
                    end
                end
            end
            pli_pkg::ST_FINAL: begin
                o_res_valid = 1'b1;
                // the inserted value lands in the gap; rewriting it while stalled is harmless
                ram_we    = (r_kind == pli_pkg::K_INS);
                ram_waddr = r_idx;
                ram_wdata = r_value;
                if (i_res_ready) begin
                    n_count = r_new_count;
                end
            end
            default: begin
                n_wb_valid = 1'b0;
            end
        endcase
    end

    // result toward the output register
    always_comb begin
        o_res.ok        = r_ok;
        o_res.status    = r_status;
        o_res.out_value = (r_kind == pli_pkg::K_REM || r_kind == pli_pkg::K_READ) ?
                          r_result : '0;
        o_res.new_count = pli_pkg::NC_W'(r_new_count);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pli_pkg::ST_IDLE;
            r_count    <= '0;
            r_wb_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_wb_valid <= n_wb_valid;
        end
    end

    // request and shift bookkeeping
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_new_count <= n_new_count;
        r_left      <= n_left;
        r_idx       <= n_idx;
        r_ptr       <= n_ptr;
        r_wb_addr   <= n_wb_addr;
        r_value     <= n_value;
        r_result    <= n_result;
        r_ok        <= n_ok;
        r_status    <= n_status;
    end

    pli_ram #(
        .WIDTH (pli_pkg::VAL_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // checks
    `PLI_ASSERT_IMPL(a_count_cap, 1'b1, r_count <= CW'(CAPACITY), "entry count above capacity")
    `PLI_ASSERT_NEXT(a_count_hold, r_state != pli_pkg::ST_FINAL, $stable(r_count), "count moved outside final")
    `PLI_ASSERT_IMPL(a_ins_count, r_state == pli_pkg::ST_FINAL && r_kind == pli_pkg::K_INS, r_new_count == r_count + 1'b1, "insert count not one up")

endmodule

// ===== rtl/positional_list_insert_remove.sv =====
// Ordered list of up to CAPACITY 32-bit values held in one single-port-write,
// registered-read RAM. Each request (append, insert front, insert at position,
// remove at position, remove last, read) returns one transaction with ok, status,
// the removed or read value and the new count. Items are handled one at a time and
// inserts and removals move the later entries through the RAM one per cycle, so
// the time from one accepted request to the next depends on k, the number of
// entries moved. A finished result sits in an output register, so the next request
// is taken while it waits. No clearing pass is needed after reset; the list starts
// empty.
module positional_list_insert_remove #(
    parameter int CAPACITY = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pli_pkg::ACT_W-1:0]     i_action,
    input  logic [pli_pkg::POS_W-1:0]     i_position,
    input  logic [pli_pkg::VAL_W-1:0]     i_item_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_ok,
    output logic [pli_pkg::ST_W-1:0]      o_status,
    output logic [pli_pkg::VAL_W-1:0]     o_out_value,
    output logic [pli_pkg::NC_W-1:0]      o_new_count
);

    logic             res_valid;
    logic             res_ready;
    pli_pkg::t_result res;
    logic             r_out_valid, n_out_valid;
    pli_pkg::t_result r_out, n_out;

    pli_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_in_valid),
        .o_req_ready  (o_in_ready),
        .i_action     (i_action),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    // output register takes a result whenever it is empty or being drained
    assign res_ready = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_ok        = r_out.ok;
    assign o_status    = r_out.status;
    assign o_out_value = r_out.out_value;
    assign o_new_count = r_out.new_count;

endmodule

// ===== tb/tb_positional_list_insert_remove.sv =====
`timescale 1ns / 1ps

module tb_positional_list_insert_remove;

    localparam int LIST_CAP       = 64;
    localparam int SH_AW          = $clog2(LIST_CAP);
    localparam int RANDOM_ITEMS   = 427;
    localparam int MAX_GAP        = 17;
    localparam int HOLD_AT        = 90;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int EXTRA_AT_EDGE  = 6;
    localparam int MIXED_LEN      = 60;

    // action codes the block does not define
    localparam logic [pli_pkg::ACT_W-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [pli_pkg::ACT_W-1:0] ACT_SPARE7 = 3'd7;

    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } t_mode;

    // one directed request with an optional hand-written result
    typedef struct {
        logic [pli_pkg::ACT_W-1:0] act;
        logic [pli_pkg::POS_W-1:0] pos;
        logic [pli_pkg::VAL_W-1:0] val;
        logic                      typed;
        pli_pkg::t_result          res;
    } t_dir_row;

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_in_valid   = 1'b0;
    logic [pli_pkg::ACT_W-1:0] i_action     = '0;
    logic [pli_pkg::POS_W-1:0] i_position   = '0;
    logic [pli_pkg::VAL_W-1:0] i_item_value = '0;
    logic                      i_out_ready  = 1'b0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic                      o_ok;
    logic [pli_pkg::ST_W-1:0]  o_status;
    logic [pli_pkg::VAL_W-1:0] o_out_value;
    logic [pli_pkg::NC_W-1:0]  o_new_count;

    // shadow copy of the list
    logic [pli_pkg::VAL_W-1:0] shadow_entries [LIST_CAP];
    int                        shadow_count = 0;

    pli_pkg::t_result pending_results [$];
    t_dir_row         dir_rows [$];
    int               mismatch_count = 0;
    int               quiet_cycles = 0;
    bit               hold_req = 1'b0;
    bit               tx_steady = 1'b0;
    bit               rx_steady = 1'b0;

    logic [pli_pkg::ACT_W-1:0] act_order [8];
    int                        act_cum [3][8];

    positional_list_insert_remove #(
        .CAPACITY(LIST_CAP)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_position  (i_position),
        .i_item_value(i_item_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ok        (o_ok),
        .o_status    (o_status),
        .o_out_value (o_out_value),
        .o_new_count (o_new_count)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // applies one request to the shadow list and returns its result
    function automatic pli_pkg::t_result list_apply(
        input logic [pli_pkg::ACT_W-1:0] act,
        input logic [pli_pkg::POS_W-1:0] pos,
        input logic [pli_pkg::VAL_W-1:0] val);
        pli_pkg::t_result res;
        logic             full;
        logic             in_range;
        logic             can_take;
        int               at;
        res.ok        = 1'b0;
        res.status    = pli_pkg::STS_BAD;
        res.out_value = '0;
        at            = 0;
        full          = (shadow_count >= LIST_CAP);
        in_range      = (int'(pos) < shadow_count);
        case (act)
            pli_pkg::ACT_APPEND, pli_pkg::ACT_FRONT, pli_pkg::ACT_INS_AT: begin
                // position check comes ahead of the full check
                if (act == pli_pkg::ACT_INS_AT && !in_range) begin
                    res.status = pli_pkg::STS_BAD;
                end else if (full) begin
                    res.status = pli_pkg::STS_FULL;
                end else begin
                    if (act == pli_pkg::ACT_APPEND)
                        at = shadow_count;
                    else if (act == pli_pkg::ACT_FRONT)
                        at = 0;
                    else
                        at = int'(pos);
                    for (int i = shadow_count; i > at; i--)
                        shadow_entries[SH_AW'(i)] = shadow_entries[SH_AW'(i-1)];
                    shadow_entries[SH_AW'(at)] = val;
                    shadow_count++;
                    res.ok     = 1'b1;
                    res.status = pli_pkg::STS_DONE;
                end
            end
            pli_pkg::ACT_REM_AT, pli_pkg::ACT_REM_LAST: begin
                if (act == pli_pkg::ACT_REM_LAST) begin
                    at       = shadow_count - 1;
                    can_take = (shadow_count > 0);
                end else begin
                    at       = int'(pos);
                    can_take = in_range;
                end
                if (can_take) begin
                    res.out_value = shadow_entries[SH_AW'(at)];
                    for (int i = at; i + 1 < shadow_count; i++)
                        shadow_entries[SH_AW'(i)] = shadow_entries[SH_AW'(i+1)];
                    shadow_count--;
                    res.ok     = 1'b1;
                    res.status = pli_pkg::STS_DONE;
                end
            end
            pli_pkg::ACT_READ: begin
                if (in_range) begin
                    res.out_value = shadow_entries[pos];
                    res.ok        = 1'b1;
                    res.status    = pli_pkg::STS_DONE;
                end
            end
            default: begin
            end
        endcase
        res.new_count = pli_pkg::NC_W'(shadow_count);
        return res;
    endfunction

    // offers one request, called and returning at a falling edge
    task automatic issue_request(input logic [pli_pkg::ACT_W-1:0] act,
                                 input logic [pli_pkg::POS_W-1:0] pos,
                                 input logic [pli_pkg::VAL_W-1:0] val, input logic typed,
                                 input pli_pkg::t_result typed_res);
        int               gap;
        pli_pkg::t_result pred;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_position   <= pos;
        i_item_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
        pred = list_apply(act, pos, val);
        pending_results.push_back(typed ? typed_res : pred);
        @(negedge i_clk);
    endtask

    task automatic add_row(input logic [pli_pkg::ACT_W-1:0] act,
                           input logic [pli_pkg::POS_W-1:0] pos,
                           input logic [pli_pkg::VAL_W-1:0] val, input logic typed,
                           input logic ok, input logic [pli_pkg::ST_W-1:0] st,
                           input logic [pli_pkg::VAL_W-1:0] ov,
                           input logic [pli_pkg::NC_W-1:0] nc);
        t_dir_row row;
        row.act           = act;
        row.pos           = pos;
        row.val           = val;
        row.typed         = typed;
        row.res.ok        = ok;
        row.res.status    = st;
        row.res.out_value = ov;
        row.res.new_count = nc;
        dir_rows.push_back(row);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        int seen;
        seen = 0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                gap      = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            seen++;
            if (seen % 40 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
            @(negedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        pli_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with none pending: ok=%0h status=%0h value=%0h",
                       o_ok, o_status, o_out_value);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_ok !== want.ok) begin
                    $error("ok: expected %0h, got %0h", want.ok, o_ok);
                    mismatch_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0h, got %0h", want.status, o_status);
                    mismatch_count++;
                end
                if (o_out_value !== want.out_value) begin
                    $error("out_value: expected %0h, got %0h", want.out_value, o_out_value);
                    mismatch_count++;
                end
                if (o_new_count !== want.new_count) begin
                    $error("new_count: expected %0d, got %0d", want.new_count, o_new_count);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        pli_pkg::t_result          no_typed;
        t_mode                     mode;
        int                        edge_hits;
        int                        mixed_items;
        int                        r;
        logic [2:0]                idx;
        logic [pli_pkg::ACT_W-1:0] act;
        logic [pli_pkg::POS_W-1:0] pos;

        no_typed = '0;
        act_order = '{pli_pkg::ACT_APPEND, pli_pkg::ACT_FRONT, pli_pkg::ACT_INS_AT,
                      pli_pkg::ACT_READ, pli_pkg::ACT_REM_AT, pli_pkg::ACT_REM_LAST,
                      ACT_SPARE6, ACT_SPARE7};
        act_cum[MODE_FILL]  = '{25, 45, 70, 80, 87, 92, 96, 100};
        act_cum[MODE_DRAIN] = '{8, 12, 18, 30, 60, 90, 95, 100};
        act_cum[MODE_MIXED] = '{15, 30, 45, 60, 75, 90, 95, 100};

        // empty list, unused codes, first inserts and reads
        add_row(pli_pkg::ACT_REM_LAST, 6'd0,  32'h0000_0000, 1'b1,
                1'b0, pli_pkg::STS_BAD, 32'h0, 7'd0);
        add_row(pli_pkg::ACT_READ,     6'd0,  32'h0000_0000, 1'b1,
                1'b0, pli_pkg::STS_BAD, 32'h0, 7'd0);
        add_row(pli_pkg::ACT_REM_AT,   6'd63, 32'h0000_0000, 1'b1,
                1'b0, pli_pkg::STS_BAD, 32'h0, 7'd0);
        add_row(pli_pkg::ACT_INS_AT,   6'd0,  32'h0000_0001, 1'b1,
                1'b0, pli_pkg::STS_BAD, 32'h0, 7'd0);
        add_row(ACT_SPARE6,            6'd63, 32'hFFFF_FFFF, 1'b1,
                1'b0, pli_pkg::STS_BAD, 32'h0, 7'd0);
        add_row(ACT_SPARE7,            6'd0,  32'hFFFF_FFFF, 1'b1,
                1'b0, pli_pkg::STS_BAD, 32'h0, 7'd0);
        add_row(pli_pkg::ACT_APPEND,   6'd63, 32'hFFFF_FFFF, 1'b1,
                1'b1, pli_pkg::STS_DONE, 32'h0, 7'd1);
        add_row(pli_pkg::ACT_FRONT,    6'd63, 32'h0000_0000, 1'b1,
                1'b1, pli_pkg::STS_DONE, 32'h0, 7'd2);
        add_row(pli_pkg::ACT_READ,     6'd0,  32'h1234_5678, 1'b1,
                1'b1, pli_pkg::STS_DONE, 32'h0, 7'd2);
        add_row(pli_pkg::ACT_READ,     6'd1,  32'h0000_0000, 1'b1,
                1'b1, pli_pkg::STS_DONE, 32'hFFFF_FFFF, 7'd2);
        add_row(pli_pkg::ACT_READ,     6'd2,  32'h0000_0000, 1'b1,
                1'b0, pli_pkg::STS_BAD, 32'h0, 7'd2);
        add_row(pli_pkg::ACT_INS_AT,   6'd1,  32'hA5A5_A5A5, 1'b0,
                1'b0, pli_pkg::STS_DONE, 32'h0, 7'd0);
        // insert exactly at the count is refused
        add_row(pli_pkg::ACT_INS_AT,   6'd3,  32'h0F0F_0F0F, 1'b1,
                1'b0, pli_pkg::STS_BAD, 32'h0, 7'd3);
        add_row(pli_pkg::ACT_INS_AT,   6'd0,  32'h5A5A_5A5A, 1'b0,
                1'b0, pli_pkg::STS_DONE, 32'h0, 7'd0);
        add_row(pli_pkg::ACT_READ,     6'd2,  32'h0000_0000, 1'b0,
                1'b0, pli_pkg::STS_DONE, 32'h0, 7'd0);
        add_row(pli_pkg::ACT_REM_AT,   6'd1,  32'h0000_0000, 1'b0,
                1'b0, pli_pkg::STS_DONE, 32'h0, 7'd0);
        add_row(pli_pkg::ACT_REM_AT,   6'd0,  32'h0000_0000, 1'b0,
                1'b0, pli_pkg::STS_DONE, 32'h0, 7'd0);
        add_row(pli_pkg::ACT_REM_LAST, 6'd0,  32'h0000_0000, 1'b0,
                1'b0, pli_pkg::STS_DONE, 32'h0, 7'd0);
        add_row(pli_pkg::ACT_REM_LAST, 6'd0,  32'h0000_0000, 1'b0,
                1'b0, pli_pkg::STS_DONE, 32'h0, 7'd0);
        add_row(pli_pkg::ACT_REM_LAST, 6'd0,  32'h0000_0000, 1'b1,
                1'b0, pli_pkg::STS_BAD, 32'h0, 7'd0);
        add_row(pli_pkg::ACT_APPEND,   6'd0,  32'h1234_5678, 1'b0,
                1'b0, pli_pkg::STS_DONE, 32'h0, 7'd0);
        add_row(pli_pkg::ACT_READ,     6'd63, 32'h0000_0000, 1'b1,
                1'b0, pli_pkg::STS_BAD, 32'h0, 7'd1);
        add_row(ACT_SPARE7,            6'd0,  32'h0000_0000, 1'b1,
                1'b0, pli_pkg::STS_BAD, 32'h0, 7'd1);

        // synchronous reset
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        foreach (dir_rows[k])
            issue_request(dir_rows[k].act, dir_rows[k].pos, dir_rows[k].val,
                          dir_rows[k].typed, dir_rows[k].res);

        // random part: fill to full, drain to empty, mixed traffic, repeat
        mode        = MODE_FILL;
        edge_hits   = 0;
        mixed_items = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT)
                hold_req = 1'b1;
            case (mode)
                MODE_FILL: begin
                    if (shadow_count == LIST_CAP)
                        edge_hits++;
                    if (edge_hits > EXTRA_AT_EDGE) begin
                        mode      = MODE_DRAIN;
                        edge_hits = 0;
                        tx_steady = ($urandom_range(0, 2) == 0);
                    end
                end
                MODE_DRAIN: begin
                    if (shadow_count == 0)
                        edge_hits++;
                    if (edge_hits > EXTRA_AT_EDGE) begin
                        mode        = MODE_MIXED;
                        edge_hits   = 0;
                        mixed_items = 0;
                        tx_steady   = ($urandom_range(0, 2) == 0);
                    end
                end
                default: begin
                    mixed_items++;
                    if (mixed_items > MIXED_LEN) begin
                        mode      = MODE_FILL;
                        tx_steady = ($urandom_range(0, 2) == 0);
                    end
                end
            endcase

            // weighted choice of action for this phase
            r   = $urandom_range(0, 99);
            idx = '0;
            while (idx < 3'd7 && r >= act_cum[mode][idx])
                idx++;
            act = act_order[idx];

            // mostly in-range positions, some anywhere
            if (shadow_count > 0 && $urandom_range(0, 99) < 80)
                pos = pli_pkg::POS_W'($urandom_range(0, shadow_count - 1));
            else
                pos = pli_pkg::POS_W'($urandom_range(0, 63));

            issue_request(act, pos, $urandom(), 1'b0, no_typed);
        end
        i_in_valid <= 1'b0;

        // wait for the last results, then let the block settle
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
